// File: sv/rlpfe_pkg.sv
// Shared types, codes and helper functions for the RGB LED PWM frame encoder.
`timescale 1ns / 1ps

package rlpfe_pkg;

    localparam int unsigned CNT_W          = 9;
    localparam int unsigned DUTY_W         = 16;
    localparam int unsigned SLOT_W         = 8;
    localparam int unsigned COLOR_W        = 24;
    localparam int unsigned BITS_PER_COLOR = 8;
    localparam int unsigned BITCNT_W       = 5;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 16;

    // Data slots per pixel: green, red, blue
    localparam logic [BITCNT_W-1:0] PIXEL_BITS = BITCNT_W'(3 * BITS_PER_COLOR);

    // Request operation codes
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_BUSY      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_SLOTS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POST_SLOTS  = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RESET,
        PH_DATA,
        PH_POST
    } phase_t;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        K_NOP,
        K_SET_OK,
        K_SET_BAD,
        K_START,
        K_TICK
    } kind_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         led_index;
        logic [COLOR_W-1:0] color;
    } request_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DUTY_W-1:0] duty;
        logic              slot_valid;
        logic              frame_last;
    } result_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         led_index;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]  led_count;
        logic [DUTY_W-1:0] duty_zero;
        logic [DUTY_W-1:0] duty_one;
        logic [SLOT_W-1:0] reset_slots;
        logic [SLOT_W-1:0] post_slots;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [CNT_W-1:0]    pix_cnt;
        logic [BITCNT_W-1:0] bit_cnt;
        logic [SLOT_W-1:0]   slot_cnt;
    } frame_t;

    // Status from the back end toward the queue logic
    typedef struct packed {
        logic clearing;
        logic inflight;
    } back_stat_t;

    localparam cfg_t CFG_RESET = '{
        led_count:   9'd0,
        duty_zero:   16'd48,
        duty_one:    16'd96,
        reset_slots: 8'd50,
        post_slots:  8'd2
    };

    // Leave every part of the frame that has no slots left
    function automatic frame_t settle(input frame_t s, input logic [CNT_W-1:0] live,
                                      input logic [SLOT_W-1:0] rs,
                                      input logic [SLOT_W-1:0] ps);
        frame_t r;
        r = s;
        if (r.phase == PH_RESET && r.slot_cnt >= rs)
        begin
            r.phase   = PH_DATA;
            r.pix_cnt = '0;
            r.bit_cnt = '0;
        end
        if (r.phase == PH_DATA && r.pix_cnt >= live)
        begin
            r.phase    = PH_POST;
            r.slot_cnt = '0;
            r.bit_cnt  = '0;
        end
        if (r.phase == PH_POST && r.slot_cnt >= ps)
        begin
            r.phase    = PH_IDLE;
            r.slot_cnt = '0;
            r.pix_cnt  = '0;
            r.bit_cnt  = '0;
        end
        return r;
    endfunction

    // Reorder a stored color (blue, green, red) into wire order (green, red, blue)
    function automatic logic [COLOR_W-1:0] grb_order(input logic [COLOR_W-1:0] c);
        return {c[15:8], c[7:0], c[23:16]};
    endfunction

endpackage

// File: sv/rlpfe_fifo.sv
// Small synchronous queue with occupancy count.
`timescale 1ns / 1ps

module rlpfe_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign count   = count_reg;
    assign rdata   = store[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: sv/rlpfe_front.sv
// Front end: request handshake and classification of each request into a command.
`timescale 1ns / 1ps

module rlpfe_front (
    input  logic                            push,
    input  rlpfe_pkg::request_t             request,
    input  logic [rlpfe_pkg::CNT_W-1:0]     live_count,
    input  logic                            blocked,
    output logic                            full,
    output logic                            cmd_push,
    output rlpfe_pkg::cmd_t                 cmd
);

    assign full     = blocked;
    assign cmd_push = push && !blocked;

    // Classify the operation; a set is checked against the live LED count here
    always_comb
    begin
        cmd.led_index = request.led_index;
        cmd.color     = request.color;
        case (request.operation)
            rlpfe_pkg::OP_SET:
            begin
                if ({1'b0, request.led_index} < live_count)
                begin
                    cmd.kind = rlpfe_pkg::K_SET_OK;
                end
                else
                begin
                    cmd.kind = rlpfe_pkg::K_SET_BAD;
                end
            end
            rlpfe_pkg::OP_START: cmd.kind = rlpfe_pkg::K_START;
            rlpfe_pkg::OP_TICK:  cmd.kind = rlpfe_pkg::K_TICK;
            default:             cmd.kind = rlpfe_pkg::K_NOP;
        endcase
    end

endmodule

// File: sv/rlpfe_back.sv
// Back end: color memory, frame sequencer and bit serializer.
`timescale 1ns / 1ps

module rlpfe_back #(
    parameter int unsigned MAX_LEDS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  rlpfe_pkg::cmd_t                 cmd,
    output logic                            cmd_pop,
    input  rlpfe_pkg::cfg_t                 cfg,
    input  logic [rlpfe_pkg::CNT_W-1:0]     live_count,
    input  logic                            res_space,
    output logic                            res_push,
    output rlpfe_pkg::result_t              res_item,
    output rlpfe_pkg::back_stat_t           stat
);

    localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

    localparam rlpfe_pkg::frame_t START_FRAME = '{
        phase:    rlpfe_pkg::PH_RESET,
        pix_cnt:  '0,
        bit_cnt:  '0,
        slot_cnt: '0
    };

    logic [rlpfe_pkg::COLOR_W-1:0] mem [MAX_LEDS];
    logic [rlpfe_pkg::COLOR_W-1:0] rdata_reg;

    logic                          clr_active_reg, clr_active_next;
    logic [AW-1:0]                 clr_addr_reg, clr_addr_next;

    rlpfe_pkg::frame_t             frame_reg, frame_next;
    rlpfe_pkg::frame_t             s0, s1, s2;

    logic                          issue;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [rlpfe_pkg::COLOR_W-1:0] wr_data;
    logic [AW-1:0]                 rd_addr;

    logic [1:0]                    a_status;
    logic                          a_slot, a_data, a_load, a_last;

    logic                          b_valid_reg;
    logic [1:0]                    b_status_reg;
    logic                          b_slot_reg, b_data_reg, b_load_reg, b_last_reg;

    logic [rlpfe_pkg::COLOR_W-1:0] shift_reg, shift_next;
    logic [rlpfe_pkg::COLOR_W-1:0] src;

    assign issue         = cmd_valid && res_space && !clr_active_reg;
    assign cmd_pop       = issue;
    assign stat.clearing = clr_active_reg;
    assign stat.inflight = b_valid_reg;

    // Sweep the color memory to zero after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    // Execute one command: memory write, frame sequencing, read request
    always_comb
    begin
        s0 = rlpfe_pkg::settle(frame_reg, live_count, cfg.reset_slots, cfg.post_slots);
        s1 = s0;
        if (s0.phase == rlpfe_pkg::PH_DATA)
        begin
            if (s0.bit_cnt + 1'b1 >= rlpfe_pkg::PIXEL_BITS)
            begin
                s1.bit_cnt = '0;
                s1.pix_cnt = s0.pix_cnt + 1'b1;
            end
            else
            begin
                s1.bit_cnt = s0.bit_cnt + 1'b1;
            end
        end
        else
        begin
            s1.slot_cnt = (s0.slot_cnt == '1) ? s0.slot_cnt : s0.slot_cnt + 1'b1;
        end
        s2 = rlpfe_pkg::settle(s1, live_count, cfg.reset_slots, cfg.post_slots);

        frame_next = frame_reg;
        a_status   = rlpfe_pkg::ST_OK;
        a_slot     = 1'b0;
        a_data     = 1'b0;
        a_load     = 1'b0;
        a_last     = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = clr_addr_reg;
        wr_data    = '0;
        rd_addr    = AW'(s0.pix_cnt);

        if (clr_active_reg)
        begin
            wr_en = 1'b1;
        end
        else if (issue)
        begin
            case (cmd.kind)
                rlpfe_pkg::K_SET_OK:
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(cmd.led_index);
                    wr_data = cmd.color;
                end
                rlpfe_pkg::K_SET_BAD:
                begin
                    a_status = rlpfe_pkg::ST_BAD_INDEX;
                end
                rlpfe_pkg::K_START:
                begin
                    if (frame_reg.phase != rlpfe_pkg::PH_IDLE)
                    begin
                        a_status = rlpfe_pkg::ST_BUSY;
                    end
                    else
                    begin
                        frame_next = rlpfe_pkg::settle(START_FRAME, live_count,
                                                       cfg.reset_slots, cfg.post_slots);
                    end
                end
                rlpfe_pkg::K_TICK:
                begin
                    if (s0.phase != rlpfe_pkg::PH_IDLE)
                    begin
                        a_slot     = 1'b1;
                        a_data     = (s0.phase == rlpfe_pkg::PH_DATA);
                        a_load     = (s0.phase == rlpfe_pkg::PH_DATA) && (s0.bit_cnt == '0);
                        a_last     = (s2.phase == rlpfe_pkg::PH_IDLE);
                        frame_next = s2;
                    end
                    else
                    begin
                        frame_next = s0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Serialize: load a pixel on its first bit, send MSB first
    always_comb
    begin
        src        = b_load_reg ? rlpfe_pkg::grb_order(rdata_reg) : shift_reg;
        shift_next = b_data_reg ? {src[rlpfe_pkg::COLOR_W-2:0], 1'b0} : shift_reg;

        res_push            = b_valid_reg;
        res_item.status     = b_status_reg;
        res_item.slot_valid = b_slot_reg;
        res_item.frame_last = b_last_reg;
        if (b_data_reg)
        begin
            res_item.duty = src[rlpfe_pkg::COLOR_W-1] ? cfg.duty_one : cfg.duty_zero;
        end
        else
        begin
            res_item.duty = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            frame_reg      <= '{phase: rlpfe_pkg::PH_IDLE, default: '0};
            b_valid_reg    <= 1'b0;
            b_status_reg   <= rlpfe_pkg::ST_OK;
            b_slot_reg     <= 1'b0;
            b_data_reg     <= 1'b0;
            b_load_reg     <= 1'b0;
            b_last_reg     <= 1'b0;
            shift_reg      <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            frame_reg      <= frame_next;
            b_valid_reg    <= issue;
            b_status_reg   <= a_status;
            b_slot_reg     <= a_slot;
            b_data_reg     <= issue && a_data;
            b_load_reg     <= issue && a_load;
            b_last_reg     <= a_last;
            shift_reg      <= shift_next;
        end
    end

    // Color memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

endmodule

// File: sv/rgb_led_pwm_frame_encoder.sv
// Top level of the RGB LED PWM frame encoder: config registers, queues, front and back end.
`timescale 1ns / 1ps

// Turns a per-LED color store into the PWM compare values of one serial LED frame.
// Requests set a color, start a frame, or tick one PWM period; every request gives
// exactly one result. One request is taken per clock cycle while the result queue has
// room and the memory is not being cleared: a request passes a command queue, an
// execute stage (counters and color memory read) and a format stage (bit serializer)
// before its result enters the result queue. After reset the color memory is cleared
// one entry per cycle, which holds full high; configuration writes are taken at any time and
// should be made only while no request is in flight.
module rgb_led_pwm_frame_encoder #(
    parameter int unsigned MAX_LEDS = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  rlpfe_pkg::request_t                   request,
    output logic                                  full,
    output logic                                  empty,
    input  logic                                  pop,
    output rlpfe_pkg::result_t                    result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rlpfe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rlpfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QCW     = $clog2(QDEPTH + 1);
    localparam int unsigned CMD_W   = $bits(rlpfe_pkg::cmd_t);
    localparam int unsigned RES_W   = $bits(rlpfe_pkg::result_t);
    localparam int unsigned CAP_INT = (MAX_LEDS > 511) ? 511 : MAX_LEDS;
    localparam logic [rlpfe_pkg::CNT_W-1:0] MAX_CAP = rlpfe_pkg::CNT_W'(CAP_INT);

    rlpfe_pkg::cfg_t                 cfg_reg, cfg_next;
    logic [rlpfe_pkg::CNT_W-1:0]     live_count;

    rlpfe_pkg::cmd_t                 front_cmd;
    logic                            front_push;
    logic [CMD_W-1:0]                cmd_q;
    logic                            cmd_empty, cmd_full, cmd_pop;
    logic [QCW-1:0]                  cmd_count;

    rlpfe_pkg::result_t              res_item;
    logic                            res_push;
    logic                            res_full;
    logic [QCW-1:0]                  res_count;
    logic                            res_space;
    rlpfe_pkg::back_stat_t           stat;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rlpfe_pkg::REG_LED_COUNT:   cfg_next.led_count   = cfg_data[8:0];
                rlpfe_pkg::REG_DUTY_ZERO:   cfg_next.duty_zero   = cfg_data;
                rlpfe_pkg::REG_DUTY_ONE:    cfg_next.duty_one    = cfg_data;
                rlpfe_pkg::REG_RESET_SLOTS: cfg_next.reset_slots = cfg_data[7:0];
                rlpfe_pkg::REG_POST_SLOTS:  cfg_next.post_slots  = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rlpfe_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Saturate the LED count at the memory depth (at most 511)
    assign live_count = (cfg_reg.led_count > MAX_CAP) ? MAX_CAP : cfg_reg.led_count;

    // Leave room in the result queue for the result still in the format stage
    assign res_space = (32'(res_count) + 32'(stat.inflight)) < QDEPTH;

    rlpfe_front u_front (
        .push       (push),
        .request    (request),
        .live_count (live_count),
        .blocked    (cmd_full || stat.clearing),
        .full       (full),
        .cmd_push   (front_push),
        .cmd        (front_cmd)
    );

    rlpfe_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QDEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_cmd),
        .pop   (cmd_pop),
        .rdata (cmd_q),
        .empty (cmd_empty),
        .full  (cmd_full),
        .count (cmd_count)
    );

    rlpfe_back #(
        .MAX_LEDS (MAX_LEDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!cmd_empty && (cmd_count != '0)),
        .cmd        (rlpfe_pkg::cmd_t'(cmd_q)),
        .cmd_pop    (cmd_pop),
        .cfg        (cfg_reg),
        .live_count (live_count),
        .res_space  (res_space),
        .res_push   (res_push),
        .res_item   (res_item),
        .stat       (stat)
    );

    rlpfe_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QDEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push && !res_full),
        .wdata (res_item),
        .pop   (pop),
        .rdata (result),
        .empty (empty),
        .full  (res_full),
        .count (res_count)
    );

endmodule
